// ----- hw/rtl/lsfg_pkg.sv -----
package lsfg_pkg;

  localparam int unsigned TIME_W  = 48;
  localparam int unsigned DELTA_W = 32;
  localparam int unsigned FREQ_W  = 22;
  localparam int unsigned LOAD_W  = 7;
  localparam int unsigned STEPS_W = 2;

  // quotient bits of the load divider: load never exceeds 100
  localparam int unsigned QBITS   = 7;
  localparam int unsigned QCNT_W  = $clog2(QBITS);
  localparam int unsigned PCT     = 100;
  // 100 * delta fits in delta width plus seven bits
  localparam int unsigned NUM_W   = DELTA_W + 7;

  localparam int unsigned STEP_KHZ = 100000;

  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  typedef enum logic [2:0] {
    REG_RESPONSIVE_FREQ    = 3'd0,
    REG_UP_LOAD_LOW_FREQ   = 3'd1,
    REG_DOWN_LOAD_LOW_FREQ = 3'd2,
    REG_UP_LOAD            = 3'd3,
    REG_DOWN_LOAD          = 3'd4,
    REG_UP_STEPS           = 3'd5,
    REG_DOWN_STEPS         = 3'd6
  } reg_idx_t;

  localparam logic [FREQ_W-1:0]  RST_RESPONSIVE_FREQ    = FREQ_W'(1134000);
  localparam logic [LOAD_W-1:0]  RST_UP_LOAD_LOW_FREQ   = LOAD_W'(70);
  localparam logic [LOAD_W-1:0]  RST_DOWN_LOAD_LOW_FREQ = LOAD_W'(70);
  localparam logic [LOAD_W-1:0]  RST_UP_LOAD            = LOAD_W'(70);
  localparam logic [LOAD_W-1:0]  RST_DOWN_LOAD          = LOAD_W'(70);
  localparam logic [STEPS_W-1:0] RST_UP_STEPS           = STEPS_W'(1);
  localparam logic [STEPS_W-1:0] RST_DOWN_STEPS         = STEPS_W'(2);

  typedef struct packed {
    logic [FREQ_W-1:0]  responsive_freq;
    logic [LOAD_W-1:0]  up_load_low_freq;
    logic [LOAD_W-1:0]  down_load_low_freq;
    logic [LOAD_W-1:0]  up_load;
    logic [LOAD_W-1:0]  down_load;
    logic [STEPS_W-1:0] up_steps;
    logic [STEPS_W-1:0] down_steps;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] wall_total;
    logic [TIME_W-1:0] idle_total;
    logic [FREQ_W-1:0] cur_freq;
    logic [FREQ_W-1:0] freq_floor;
    logic [FREQ_W-1:0] freq_ceil;
  } in_t;

  typedef struct packed {
    logic              evaluated;
    logic [LOAD_W-1:0] load_pct;
    logic [FREQ_W-1:0] target_freq;
    logic              change_req;
  } out_t;

  typedef struct packed {
    logic              capture;
    logic              mul;
    logic              div_step;
    logic [QCNT_W-1:0] div_bit;
    logic              finish;
  } cmd_t;

endpackage

// ----- hw/rtl/lsfg_ctrl.sv -----
module lsfg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output lsfg_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DEC
  } state_t;

  state_t                         state;
  logic [lsfg_pkg::QCNT_W-1:0]    bit_cnt;
  logic                           out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state == S_IDLE) && in_valid;
    cmd.mul      = (state == S_MUL);
    cmd.div_step = (state == S_DIV);
    cmd.div_bit  = bit_cnt;
    cmd.finish   = (state == S_DEC) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bit_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DEC) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          bit_cnt <= lsfg_pkg::QCNT_W'(lsfg_pkg::QBITS - 1);
          state   <= S_DIV;
        end
        S_DIV: begin
          if (bit_cnt == '0) begin
            state <= S_DEC;
          end else begin
            bit_cnt <= bit_cnt - 1'b1;
          end
        end
        S_DEC: begin
          // hold the result until the output register can take it
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/lsfg_dp.sv -----
module lsfg_dp (
  input  logic             clk,
  input  logic             rst,
  input  lsfg_pkg::cmd_t   cmd,
  input  lsfg_pkg::in_t    in_data,
  input  lsfg_pkg::cfg_t   cfg,
  output lsfg_pkg::out_t   out_data
);

  localparam int unsigned FW = lsfg_pkg::FREQ_W;

  logic [lsfg_pkg::TIME_W-1:0]  prev_wall;
  logic [lsfg_pkg::TIME_W-1:0]  prev_idle;
  logic [lsfg_pkg::DELTA_W-1:0] dw;
  logic [lsfg_pkg::DELTA_W-1:0] di;
  logic [FW-1:0]                cur;
  logic [FW-1:0]                lo;
  logic [FW-1:0]                hi;
  logic                         eval;
  logic                         eq;
  logic [lsfg_pkg::NUM_W-1:0]   rem;
  logic [lsfg_pkg::QBITS-1:0]   quo;

  logic [lsfg_pkg::NUM_W-1:0]   dsh;
  logic [lsfg_pkg::LOAD_W-1:0]  load;
  logic [lsfg_pkg::LOAD_W-1:0]  up_th;
  logic [lsfg_pkg::LOAD_W-1:0]  dn_th;
  logic [FW:0]                  up_amt;
  logic [FW:0]                  dn_amt;
  logic [FW:0]                  raised;
  logic [FW:0]                  lowered;
  logic [FW-1:0]                next_up;
  logic [FW-1:0]                next_dn;
  logic [FW-1:0]                freq_sel;
  logic                         rise;
  logic                         fall;

  // divisor aligned to the quotient bit under test
  assign dsh = lsfg_pkg::NUM_W'(dw) << cmd.div_bit;

  always_comb begin
    if (!eval) begin
      load = '0;
    end else if (eq) begin
      load = lsfg_pkg::LOAD_W'(1);
    end else begin
      load = quo;
    end

    if (cur < cfg.responsive_freq) begin
      up_th = cfg.up_load_low_freq;
      dn_th = cfg.down_load_low_freq;
    end else begin
      up_th = cfg.up_load;
      dn_th = cfg.down_load;
    end

    up_amt  = (FW+1)'(cfg.up_steps) * (FW+1)'(lsfg_pkg::STEP_KHZ);
    dn_amt  = (FW+1)'(cfg.down_steps) * (FW+1)'(lsfg_pkg::STEP_KHZ);
    raised  = {1'b0, cur} + up_amt;
    lowered = {1'b0, cur} - dn_amt;

    next_up = (raised > {1'b0, hi}) ? hi : raised[FW-1:0];
    // saturate at the floor, also when the step would go below zero
    next_dn = (({1'b0, cur} > dn_amt) && (lowered[FW-1:0] > lo)) ? lowered[FW-1:0] : lo;

    rise = (load >= up_th) && (cur < hi);
    fall = (load < dn_th) && (cur > lo);

    if (!eval) begin
      freq_sel = cur;
    end else if (rise) begin
      freq_sel = next_up;
    end else if (fall) begin
      freq_sel = next_dn;
    end else begin
      freq_sel = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_wall <= '0;
      prev_idle <= '0;
    end else if (cmd.capture) begin
      prev_wall <= in_data.wall_total;
      prev_idle <= in_data.idle_total;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dw  <= in_data.wall_total[lsfg_pkg::DELTA_W-1:0] - prev_wall[lsfg_pkg::DELTA_W-1:0];
      di  <= in_data.idle_total[lsfg_pkg::DELTA_W-1:0] - prev_idle[lsfg_pkg::DELTA_W-1:0];
      cur <= in_data.cur_freq;
      lo  <= in_data.freq_floor;
      hi  <= in_data.freq_ceil;
    end
    if (cmd.mul) begin
      eval <= (dw >= di);
      eq   <= (dw == di);
      rem  <= lsfg_pkg::NUM_W'(dw - di) * lsfg_pkg::NUM_W'(lsfg_pkg::PCT);
      quo  <= '0;
    end
    if (cmd.div_step) begin
      if (rem >= dsh) begin
        rem              <= rem - dsh;
        quo[cmd.div_bit] <= 1'b1;
      end
    end
    if (cmd.finish) begin
      out_data.evaluated   <= eval;
      out_data.load_pct    <= load;
      out_data.target_freq <= freq_sel;
      out_data.change_req  <= (freq_sel != cur);
    end
  end

endmodule

// ----- hw/rtl/load_stepped_frequency_governor_top.sv -----
// Stepped load governor: each input beat carries cumulative wall and idle
// times plus the current frequency and policy limits; the block forms 32-bit
// deltas against the previous sample, computes the load percent and returns one
// result beat with the target frequency. An accepted sample passes through a
// capture, a multiply, the restoring load divider, which resolves one quotient
// bit per cycle, and a decision step that loads its result register; the next
// sample is taken only once that result has moved into the output register.
// A finished result sits in an output register, so a stalled output
// does not hold off the next sample until that sample's own result is ready.
// The user must write thresholds and step counts over the register port only
// while idle; the block itself does not enforce it.
module load_stepped_frequency_governor_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  lsfg_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output lsfg_pkg::out_t                 out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lsfg_pkg::ADDR_W-1:0]    paddr,
  input  logic [lsfg_pkg::DATA_W-1:0]    pwdata,
  output logic [lsfg_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  lsfg_pkg::cfg_t    cfg;
  lsfg_pkg::cmd_t    cmd;
  lsfg_pkg::reg_idx_t reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = lsfg_pkg::reg_idx_t'(paddr[lsfg_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.responsive_freq    <= lsfg_pkg::RST_RESPONSIVE_FREQ;
      cfg.up_load_low_freq   <= lsfg_pkg::RST_UP_LOAD_LOW_FREQ;
      cfg.down_load_low_freq <= lsfg_pkg::RST_DOWN_LOAD_LOW_FREQ;
      cfg.up_load            <= lsfg_pkg::RST_UP_LOAD;
      cfg.down_load          <= lsfg_pkg::RST_DOWN_LOAD;
      cfg.up_steps           <= lsfg_pkg::RST_UP_STEPS;
      cfg.down_steps         <= lsfg_pkg::RST_DOWN_STEPS;
    end else if (wr_en) begin
      case (reg_idx)
        lsfg_pkg::REG_RESPONSIVE_FREQ:
          cfg.responsive_freq <= pwdata[lsfg_pkg::FREQ_W-1:0];
        lsfg_pkg::REG_UP_LOAD_LOW_FREQ:
          cfg.up_load_low_freq <= pwdata[lsfg_pkg::LOAD_W-1:0];
        lsfg_pkg::REG_DOWN_LOAD_LOW_FREQ:
          cfg.down_load_low_freq <= pwdata[lsfg_pkg::LOAD_W-1:0];
        lsfg_pkg::REG_UP_LOAD:
          cfg.up_load <= pwdata[lsfg_pkg::LOAD_W-1:0];
        lsfg_pkg::REG_DOWN_LOAD:
          cfg.down_load <= pwdata[lsfg_pkg::LOAD_W-1:0];
        lsfg_pkg::REG_UP_STEPS:
          cfg.up_steps <= pwdata[lsfg_pkg::STEPS_W-1:0];
        lsfg_pkg::REG_DOWN_STEPS:
          cfg.down_steps <= pwdata[lsfg_pkg::STEPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lsfg_pkg::REG_RESPONSIVE_FREQ:
        prdata = lsfg_pkg::DATA_W'(cfg.responsive_freq);
      lsfg_pkg::REG_UP_LOAD_LOW_FREQ:
        prdata = lsfg_pkg::DATA_W'(cfg.up_load_low_freq);
      lsfg_pkg::REG_DOWN_LOAD_LOW_FREQ:
        prdata = lsfg_pkg::DATA_W'(cfg.down_load_low_freq);
      lsfg_pkg::REG_UP_LOAD:
        prdata = lsfg_pkg::DATA_W'(cfg.up_load);
      lsfg_pkg::REG_DOWN_LOAD:
        prdata = lsfg_pkg::DATA_W'(cfg.down_load);
      lsfg_pkg::REG_UP_STEPS:
        prdata = lsfg_pkg::DATA_W'(cfg.up_steps);
      lsfg_pkg::REG_DOWN_STEPS:
        prdata = lsfg_pkg::DATA_W'(cfg.down_steps);
      default:
        prdata = '0;
    endcase
  end

  lsfg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lsfg_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg      (cfg),
    .out_data (out_data)
  );

  // a sample in work blocks the input side on the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a sample is in work");

  // a sample with no decision reports zero load and no change
  a_no_eval_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.evaluated |-> out_data.load_pct == '0 && !out_data.change_req)
    else $error("unevaluated result carries a decision");

  // the load percent never exceeds one hundred
  a_load_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.load_pct <= lsfg_pkg::LOAD_W'(lsfg_pkg::PCT))
    else $error("load percent out of range");

  // the result is only loaded into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result overwritten");

endmodule

// ----- sim/load_stepped_frequency_governor_top_tb.sv -----
`timescale 1ns / 100ps

module load_stepped_frequency_governor_top_tb;

  localparam logic [2:0] UNMAPPED_IDX = 3'd7;
  localparam int REG_W [7] = '{lsfg_pkg::FREQ_W, lsfg_pkg::LOAD_W, lsfg_pkg::LOAD_W,
                               lsfg_pkg::LOAD_W, lsfg_pkg::LOAD_W, lsfg_pkg::STEPS_W,
                               lsfg_pkg::STEPS_W};
  localparam int RAND_PER_SETTING = 215;
  localparam int TAIL_CYCLES = 30;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  lsfg_pkg::in_t                 in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  lsfg_pkg::out_t                out_data;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [lsfg_pkg::ADDR_W-1:0]   paddr = '0;
  logic [lsfg_pkg::DATA_W-1:0]   pwdata = '0;
  logic [lsfg_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  load_stepped_frequency_governor_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // governor state as the block should hold it
  lsfg_pkg::cfg_t gov_cfg = '{lsfg_pkg::RST_RESPONSIVE_FREQ, lsfg_pkg::RST_UP_LOAD_LOW_FREQ,
                              lsfg_pkg::RST_DOWN_LOAD_LOW_FREQ, lsfg_pkg::RST_UP_LOAD,
                              lsfg_pkg::RST_DOWN_LOAD, lsfg_pkg::RST_UP_STEPS,
                              lsfg_pkg::RST_DOWN_STEPS};
  logic [47:0] last_wall = '0;
  logic [47:0] last_idle = '0;
  // totals most recently generated for the random samples
  logic [47:0] gen_wall = '0;
  logic [47:0] gen_idle = '0;

  lsfg_pkg::out_t pending_decisions [$];
  bit   calm = 1'b0;
  int   fails = 0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   n_settings = 1;
  int   n_up = 0;
  int   n_down = 0;
  int   n_held = 0;
  int   n_skipped = 0;

  typedef struct {
    lsfg_pkg::in_t  smp;
    bit             typed;
    lsfg_pkg::out_t want;
  } plan_row_t;

  // cumulative totals; the previous row is the baseline of each delta
  plan_row_t plan [20] = '{
    '{'{48'd0, 48'd0, 22'd1000000, 22'd300000, 22'd2000000},
      1'b1, '{1'b1, 7'd1, 22'd800000, 1'b1}},
    '{'{48'd1000, 48'd2000, 22'd1500000, 22'd300000, 22'd2000000},
      1'b1, '{1'b0, 7'd0, 22'd1500000, 1'b0}},
    '{'{48'd2000, 48'd2000, 22'd1500000, 22'd300000, 22'd2000000},
      1'b1, '{1'b1, 7'd100, 22'd1600000, 1'b1}},
    '{'{48'd3000, 48'd2000, 22'd1950000, 22'd300000, 22'd2000000},
      1'b1, '{1'b1, 7'd100, 22'd2000000, 1'b1}},
    '{'{48'd4000, 48'd2000, 22'd2000000, 22'd300000, 22'd2000000},
      1'b1, '{1'b1, 7'd100, 22'd2000000, 1'b0}},
    '{'{48'd5000, 48'd2999, 22'd400000, 22'd300000, 22'd2000000},
      1'b1, '{1'b1, 7'd0, 22'd300000, 1'b1}},
    '{'{48'd6000, 48'd3998, 22'd150000, 22'd100000, 22'd2000000},
      1'b1, '{1'b1, 7'd0, 22'd100000, 1'b1}},
    '{'{48'd7000, 48'd4997, 22'd100000, 22'd0, 22'd0},
      1'b1, '{1'b1, 7'd0, 22'd0, 1'b1}},
    '{'{48'hFFFF_FFFF_FFFF, 48'd0, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF},
      1'b1, '{1'b0, 7'd0, 22'h3FFFFF, 1'b0}},
    '{'{48'd0, 48'hFFFF_FFFF_FFFF, 22'd0, 22'd0, 22'h3FFFFF},
      1'b1, '{1'b0, 7'd0, 22'd0, 1'b0}},
    '{'{48'd5, 48'd1, 22'd0, 22'd0, 22'h3FFFFF}, 1'b0, '0},
    '{'{48'd105, 48'd31, 22'd1000000, 22'd0, 22'h3FFFFF}, 1'b0, '0},
    '{'{48'd205, 48'd62, 22'd1200000, 22'd0, 22'h3FFFFF}, 1'b0, '0},
    '{'{48'd305, 48'd62, 22'd2000000, 22'd3000000, 22'd1000000}, 1'b0, '0},
    '{'{48'd405, 48'd162, 22'd2000000, 22'd3000000, 22'd1000000}, 1'b0, '0},
    '{'{48'd505, 48'd162, 22'd500000, 22'd3000000, 22'd1000000}, 1'b0, '0},
    '{'{48'd4294967800, 48'd162, 22'h3FFFFF, 22'd0, 22'h3FFFFF}, 1'b0, '0},
    '{'{48'd8589935095, 48'd4294967456, 22'h3FFFFF, 22'd0, 22'h3FFFFF}, 1'b0, '0},
    '{'{48'd12884902401, 48'd4294967460, 22'd1134000, 22'd0, 22'h3FFFFF}, 1'b0, '0},
    '{'{48'd12884902501, 48'd4294967460, 22'd1133999, 22'd0, 22'h3FFFFF}, 1'b0, '0}
  };

  function automatic lsfg_pkg::out_t decide_freq(lsfg_pkg::in_t s);
    logic [31:0]    dw;
    logic [31:0]    di;
    logic [63:0]    load;
    logic [63:0]    cur;
    logic [63:0]    lo;
    logic [63:0]    hi;
    logic [63:0]    nxt;
    logic [63:0]    drop;
    logic [6:0]     up_th;
    logic [6:0]     dn_th;
    lsfg_pkg::out_t r;
    dw = 32'(s.wall_total - last_wall);
    di = 32'(s.idle_total - last_idle);
    last_wall = s.wall_total;
    last_idle = s.idle_total;
    cur = 64'(s.cur_freq);
    lo = 64'(s.freq_floor);
    hi = 64'(s.freq_ceil);
    load = '0;
    nxt = cur;
    if (dw >= di) begin
      if (dw > di) begin
        load = (64'd100 * 64'(dw - di)) / 64'(dw);
      end else begin
        load = 64'd1;
      end
      if (cur < 64'(gov_cfg.responsive_freq)) begin
        up_th = gov_cfg.up_load_low_freq;
        dn_th = gov_cfg.down_load_low_freq;
      end else begin
        up_th = gov_cfg.up_load;
        dn_th = gov_cfg.down_load;
      end
      if (load >= 64'(up_th) && cur < hi) begin
        nxt = cur + 64'(gov_cfg.up_steps) * 64'(lsfg_pkg::STEP_KHZ);
        if (nxt > hi) nxt = hi;
      end else if (load < 64'(dn_th) && cur > lo) begin
        drop = 64'(gov_cfg.down_steps) * 64'(lsfg_pkg::STEP_KHZ);
        // saturate at the floor, including a drop below zero
        if (cur > drop && cur - drop > lo) nxt = cur - drop;
        else nxt = lo;
      end
      if (nxt > cur) n_up++;
      else if (nxt < cur) n_down++;
      else n_held++;
    end else begin
      n_skipped++;
    end
    r.evaluated = dw >= di;
    r.load_pct = load[6:0];
    r.target_freq = nxt[21:0];
    r.change_req = nxt != cur;
    return r;
  endfunction

  function automatic lsfg_pkg::in_t make_sample();
    lsfg_pkg::in_t s;
    logic [63:0]   span;
    logic [47:0]   dw;
    logic [47:0]   di;
    logic [21:0]   lo;
    logic [21:0]   hi;
    logic [21:0]   cur;
    logic [21:0]   rf;
    int unsigned   pct;
    int unsigned   kind;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 6))
      0: span = '0;
      1, 2: span = 64'($urandom);
      default: span = 64'($urandom_range(1, 20000));
    endcase
    pct = $urandom_range(0, 100);
    dw = span[47:0];
    di = dw - 48'((span * pct) / 100);
    if (di < dw && $urandom_range(0, 1)) di = di + 48'd1;
    if (kind < 8) begin
      // idle ahead of wall: no decision
      di = dw + 48'($urandom_range(1, 5000));
    end else if (kind < 16) begin
      // bits above the 32-bit delta must be dropped
      dw = dw + (48'($urandom_range(1, 65535)) << 32);
    end
    if (kind >= 91) begin
      gen_wall = 48'({$urandom, $urandom});
      gen_idle = 48'({$urandom, $urandom});
    end else begin
      gen_wall = gen_wall + dw;
      gen_idle = gen_idle + di;
    end
    rf = gov_cfg.responsive_freq;
    if ($urandom_range(0, 6) == 0) begin
      lo = 22'($urandom);
      hi = 22'($urandom);
      cur = 22'($urandom);
    end else begin
      lo = 22'($urandom_range(0, 1500000));
      hi = 22'($urandom_range(lo, 4194303));
      case ($urandom_range(0, 7))
        0: cur = lo;
        1: cur = hi;
        2: cur = rf - 22'd1;
        3: cur = rf;
        4: cur = lo + 22'($urandom_range(0, 300000));
        5: cur = hi - 22'($urandom_range(0, 300000));
        default: cur = 22'($urandom_range(lo, hi));
      endcase
    end
    s = '{gen_wall, gen_idle, cur, lo, hi};
    return s;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      lsfg_pkg::REG_RESPONSIVE_FREQ:
        gov_cfg.responsive_freq = v[lsfg_pkg::FREQ_W-1:0];
      lsfg_pkg::REG_UP_LOAD_LOW_FREQ:
        gov_cfg.up_load_low_freq = v[lsfg_pkg::LOAD_W-1:0];
      lsfg_pkg::REG_DOWN_LOAD_LOW_FREQ:
        gov_cfg.down_load_low_freq = v[lsfg_pkg::LOAD_W-1:0];
      lsfg_pkg::REG_UP_LOAD:
        gov_cfg.up_load = v[lsfg_pkg::LOAD_W-1:0];
      lsfg_pkg::REG_DOWN_LOAD:
        gov_cfg.down_load = v[lsfg_pkg::LOAD_W-1:0];
      lsfg_pkg::REG_UP_STEPS:
        gov_cfg.up_steps = v[lsfg_pkg::STEPS_W-1:0];
      lsfg_pkg::REG_DOWN_STEPS:
        gov_cfg.down_steps = v[lsfg_pkg::STEPS_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] reg_value(lsfg_pkg::reg_idx_t idx);
    case (idx)
      lsfg_pkg::REG_RESPONSIVE_FREQ:    return 32'(gov_cfg.responsive_freq);
      lsfg_pkg::REG_UP_LOAD_LOW_FREQ:   return 32'(gov_cfg.up_load_low_freq);
      lsfg_pkg::REG_DOWN_LOAD_LOW_FREQ: return 32'(gov_cfg.down_load_low_freq);
      lsfg_pkg::REG_UP_LOAD:            return 32'(gov_cfg.up_load);
      lsfg_pkg::REG_DOWN_LOAD:          return 32'(gov_cfg.down_load);
      lsfg_pkg::REG_UP_STEPS:           return 32'(gov_cfg.up_steps);
      lsfg_pkg::REG_DOWN_STEPS:         return 32'(gov_cfg.down_steps);
      default:                          return '0;
    endcase
  endfunction

  // half the writes carry junk above the register width
  function automatic logic [31:0] junk(logic [31:0] v, int w);
    return $urandom_range(0, 1) ? v : (v | ($urandom << w));
  endfunction

  function automatic logic [31:0] rand_thr();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(20, 90);
  endfunction

  task automatic apb(input bit wr, input logic [2:0] idx, input logic [31:0] wd,
                     output logic [31:0] rd);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wd;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (wr) apply_reg(idx, wd);
  endtask

  task automatic check_regs();
    logic [31:0]        rd;
    lsfg_pkg::reg_idx_t ri;
    for (int r = 0; r < 7; r++) begin
      ri = lsfg_pkg::reg_idx_t'(r);
      apb(1'b0, 3'(r), '0, rd);
      if (rd !== reg_value(ri)) begin
        $error("%s: expected %0h, got %0h", ri.name(), reg_value(ri), rd);
        fails++;
      end
    end
  endtask

  task automatic set_regs(input logic [31:0] rf, input logic [31:0] ul, input logic [31:0] dl,
                          input logic [31:0] u, input logic [31:0] d, input logic [31:0] us,
                          input logic [31:0] ds);
    logic [31:0] vals [7];
    logic [31:0] rd;
    vals = '{rf, ul, dl, u, d, us, ds};
    for (int r = 0; r < 7; r++) apb(1'b1, 3'(r), junk(vals[r], REG_W[r]), rd);
    check_regs();
    n_settings++;
  endtask

  task automatic send_sample(input lsfg_pkg::in_t s, input bit typed,
                             input lsfg_pkg::out_t want);
    lsfg_pkg::out_t predicted;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (in_stall);
    predicted = decide_freq(s);
    pending_decisions.push_back(typed ? want : predicted);
    n_sent++;
  endtask

  task automatic run_phase(int n);
    repeat (n) send_sample(make_sample(), 1'b0, '0);
    in_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
  endtask

  // result side: random stall bursts
  initial begin
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    lsfg_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_decisions.size() == 0) begin
        $error("out_data: result beat with no decision pending");
        fails++;
      end else begin
        want = pending_decisions.pop_front();
        n_checked++;
        if (out_data.evaluated !== want.evaluated) begin
          $error("evaluated: expected %0d, got %0d", want.evaluated, out_data.evaluated);
          fails++;
        end
        if (out_data.load_pct !== want.load_pct) begin
          $error("load_pct: expected %0d, got %0d", want.load_pct, out_data.load_pct);
          fails++;
        end
        if (out_data.target_freq !== want.target_freq) begin
          $error("target_freq: expected %0d, got %0d", want.target_freq,
                 out_data.target_freq);
          fails++;
        end
        if (out_data.change_req !== want.change_req) begin
          $error("change_req: expected %0d, got %0d", want.change_req, out_data.change_req);
          fails++;
        end
      end
    end
  end

  initial begin
    logic [31:0] rd;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    check_regs();

    foreach (plan[k]) send_sample(plan[k].smp, plan[k].typed, plan[k].want);
    in_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);

    set_regs($urandom_range(0, 4194303), $urandom_range(0, 100), $urandom_range(0, 95),
             $urandom_range(0, 100), $urandom_range(5, 95), $urandom_range(1, 3),
             $urandom_range(1, 3));
    // a write past the last register must leave everything alone
    apb(1'b1, UNMAPPED_IDX, $urandom, rd);
    check_regs();
    run_phase(RAND_PER_SETTING);

    // zero thresholds and zero step counts
    set_regs(0, 0, 0, 0, 0, 0, 0);
    run_phase(RAND_PER_SETTING);

    // thresholds above 100: never rise, fall on every evaluated sample above the floor
    set_regs(4194303, 127, 127, 127, 127, 3, 3);
    run_phase(RAND_PER_SETTING);

    set_regs($urandom_range(0, 4194303), 100, 95, 100, 95, 3, 1);
    run_phase(RAND_PER_SETTING);

    repeat (3) begin
      set_regs($urandom_range(0, 4194303), rand_thr(), rand_thr(), rand_thr(), rand_thr(),
               $urandom_range(0, 3), $urandom_range(0, 3));
      run_phase(RAND_PER_SETTING);
    end

    // closing stretch at full rate
    calm = 1'b1;
    set_regs(32'(lsfg_pkg::RST_RESPONSIVE_FREQ), 32'(lsfg_pkg::RST_UP_LOAD_LOW_FREQ),
             32'(lsfg_pkg::RST_DOWN_LOAD_LOW_FREQ), 32'(lsfg_pkg::RST_UP_LOAD),
             32'(lsfg_pkg::RST_DOWN_LOAD), 32'(lsfg_pkg::RST_UP_STEPS),
             32'(lsfg_pkg::RST_DOWN_STEPS));
    run_phase(RAND_PER_SETTING);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d samples over %0d register settings, %0d result beats checked",
             n_sent, n_settings, n_checked);
    $display("decisions: %0d up, %0d down, %0d held, %0d skipped with idle ahead of wall",
             n_up, n_down, n_held, n_skipped);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
